// ===== design/bwiq_pkg.sv =====
// Shared types and constants for the button and wheel input qualifier.
package bwiq_pkg;

  // Width of every configuration register and of the wheel level field
  localparam int CFG_W   = 16;
  localparam int LEVEL_W = 16;

  // Configuration port index width and register indexes
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DOUBLE_CLICK_MS     = 3'd0,
    CFG_BUTTON_LOCKOUT_MS   = 3'd1,
    CFG_WHEEL_LOCKOUT_MS    = 3'd2,
    CFG_WHEEL_MIDDLE        = 3'd3,
    CFG_WHEEL_UP_SPAN       = 3'd4,
    CFG_WHEEL_DOWN_SPAN     = 3'd5,
    CFG_WHEEL_RELEASE_LEVEL = 3'd6
  } cfg_idx_t;

  // Register values after reset
  localparam logic [CFG_W-1:0] RST_DOUBLE_CLICK_MS     = 16'd400;
  localparam logic [CFG_W-1:0] RST_BUTTON_LOCKOUT_MS   = 16'd200;
  localparam logic [CFG_W-1:0] RST_WHEEL_LOCKOUT_MS    = 16'd200;
  localparam logic [CFG_W-1:0] RST_WHEEL_MIDDLE        = 16'd32768;
  localparam logic [CFG_W-1:0] RST_WHEEL_UP_SPAN       = 16'd16384;
  localparam logic [CFG_W-1:0] RST_WHEEL_DOWN_SPAN     = 16'd16384;
  localparam logic [CFG_W-1:0] RST_WHEEL_RELEASE_LEVEL = 16'd6554;

  // Stream payload widths (padded to whole bytes)
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  // Control of one millisecond timer for the current transaction
  typedef struct packed {
    logic start;
    logic stop;
  } tmr_ctrl_t;

endpackage

// ===== design/bwiq_timer.sv =====
// Saturating millisecond timer with a running flag, advanced once per transaction.
module bwiq_timer
  import bwiq_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  tick_en,
  input  tmr_ctrl_t             ctrl,
  output logic [TIMER_BITS-1:0] count
);

  logic [TIMER_BITS-1:0] count_r, count_nxt;
  logic                  running_r, running_nxt;

  // Apply stop or start, then count up while running, holding at the top
  always_comb begin
    running_nxt = running_r;
    count_nxt   = count_r;
    if (ctrl.stop) begin
      running_nxt = 1'b0;
      count_nxt   = '0;
    end else begin
      if (ctrl.start) begin
        running_nxt = 1'b1;
      end
      if (running_nxt && (count_r != {TIMER_BITS{1'b1}})) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      count_r   <= '0;
    end else if (tick_en) begin
      running_r <= running_nxt;
      count_r   <= count_nxt;
    end
  end

  assign count = count_r;

endmodule

// ===== design/button_wheel_input_qualifier_unit.sv =====
// Top level of the button and wheel input qualifier.
//
// Usage: feed one transaction per millisecond tick on the in_ stream carrying
// the green and red button levels and the averaged wheel level. Every input
// transaction yields exactly one out_ transaction with five event pulses:
// green click, red click, double click, wheel up and wheel down.
// Thresholds and lockout times are written through the cfg_ port while the
// stream is idle; a write takes effect at the clock edge where cfg_we is high.
//
// An accepted item is held in the input register, its result is computed from
// there and registered in the output stage, so out_tvalid rises once the item
// has passed the input register and the output register. Throughput: one item
// per cycle while out_tready is high, set by the single update of the arm flags
// and the three timers in the result stage.
//
// Reset (synchronous, rst_n low): buttons and wheel armed, all timers
// stopped at zero, registers at their default values, both stages empty.
// When the receiver holds out_tready low the result stays in the output
// register, the input stage keeps one more item, and then in_tready drops.
module button_wheel_input_qualifier_unit
  import bwiq_pkg::*;
#(
  parameter int TIMER_BITS = 16,
  parameter int LEVEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [0] green_pressed, [1] red_pressed, [17:2] wheel_level, [23:18] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] green_click, [1] red_click, [2] double_click, [3] wheel_up,
  // [4] wheel_down, [7:5] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam int LVL_LSB = CFG_W - LEVEL_BITS;

  // Configuration registers
  logic [CFG_W-1:0] dbl_ms_r, btn_lock_r, whl_lock_r;
  logic [CFG_W-1:0] whl_mid_r, whl_up_span_r, whl_dn_span_r, whl_rel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbl_ms_r      <= RST_DOUBLE_CLICK_MS;
      btn_lock_r    <= RST_BUTTON_LOCKOUT_MS;
      whl_lock_r    <= RST_WHEEL_LOCKOUT_MS;
      whl_mid_r     <= RST_WHEEL_MIDDLE;
      whl_up_span_r <= RST_WHEEL_UP_SPAN;
      whl_dn_span_r <= RST_WHEEL_DOWN_SPAN;
      whl_rel_r     <= RST_WHEEL_RELEASE_LEVEL;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DOUBLE_CLICK_MS:     dbl_ms_r      <= cfg_wdata;
        CFG_BUTTON_LOCKOUT_MS:   btn_lock_r    <= cfg_wdata;
        CFG_WHEEL_LOCKOUT_MS:    whl_lock_r    <= cfg_wdata;
        CFG_WHEEL_MIDDLE:        whl_mid_r     <= cfg_wdata;
        CFG_WHEEL_UP_SPAN:       whl_up_span_r <= cfg_wdata;
        CFG_WHEEL_DOWN_SPAN:     whl_dn_span_r <= cfg_wdata;
        CFG_WHEEL_RELEASE_LEVEL: whl_rel_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input stage
  logic                  s1_valid_r;
  logic                  s1_green_r, s1_red_r;
  logic [LEVEL_BITS-1:0] s1_level_r;
  logic                  out_valid_r;
  logic [4:0]            out_flags_r, out_flags_nxt;
  logic                  advance;
  logic                  step;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign step      = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // Keep only the level bits that take part in the compares
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_green_r <= in_tdata[0];
      s1_red_r   <= in_tdata[1];
      s1_level_r <= in_tdata[2+CFG_W-1 -: LEVEL_BITS];
    end
  end

  // Timers
  tmr_ctrl_t             btn_ctrl, pair_ctrl, whl_ctrl;
  logic [TIMER_BITS-1:0] btn_cnt, pair_cnt, whl_cnt;

  bwiq_timer #(.TIMER_BITS(TIMER_BITS)) u_btn_timer (
    .clk(clk), .rst_n(rst_n), .tick_en(step), .ctrl(btn_ctrl),
    .count(btn_cnt)
  );

  bwiq_timer #(.TIMER_BITS(TIMER_BITS)) u_pair_timer (
    .clk(clk), .rst_n(rst_n), .tick_en(step), .ctrl(pair_ctrl),
    .count(pair_cnt)
  );

  bwiq_timer #(.TIMER_BITS(TIMER_BITS)) u_whl_timer (
    .clk(clk), .rst_n(rst_n), .tick_en(step), .ctrl(whl_ctrl),
    .count(whl_cnt)
  );

  // Arm flags
  logic btn_armed_r, btn_armed_nxt;
  logic whl_armed_r, whl_armed_nxt;
  logic first_seen_r, first_seen_nxt;

  // Button decision
  logic btn_idle, pair_idle, whl_idle;
  logic g_click, r_click, click, btn_rearm, pair_drop, dbl_hit;

  assign btn_idle  = (btn_cnt == '0);
  assign pair_idle = (pair_cnt == '0);
  assign whl_idle  = (whl_cnt == '0);

  assign g_click   = btn_armed_r && s1_green_r && btn_idle;
  assign r_click   = btn_armed_r && !s1_green_r && s1_red_r && btn_idle;
  assign click     = g_click || r_click;
  assign btn_rearm = !btn_armed_r && !s1_green_r && !s1_red_r &&
                     (CMP_W'(btn_cnt) > CMP_W'(btn_lock_r));
  assign pair_drop = !click && !btn_rearm && (CMP_W'(pair_cnt) > CMP_W'(dbl_ms_r));
  assign dbl_hit   = click && !pair_idle && first_seen_r &&
                     (CMP_W'(pair_cnt) <= CMP_W'(dbl_ms_r));

  // Wheel windows at the chosen level resolution
  logic [LEVEL_BITS-1:0] lvl, mid, up_span, dn_span, rel;
  logic [LEVEL_BITS:0]   up_edge, lvl_plus_dn;
  logic                  whl_up, whl_down, whl_rearm;

  assign lvl         = s1_level_r;
  assign mid         = whl_mid_r[CFG_W-1:LVL_LSB];
  assign up_span     = whl_up_span_r[CFG_W-1:LVL_LSB];
  assign dn_span     = whl_dn_span_r[CFG_W-1:LVL_LSB];
  assign rel         = whl_rel_r[CFG_W-1:LVL_LSB];
  assign up_edge     = {1'b0, mid} + {1'b0, up_span};
  // lvl > mid - dn_span, kept unsigned
  assign lvl_plus_dn = {1'b0, lvl} + {1'b0, dn_span};

  assign whl_up    = whl_armed_r && whl_idle && (lvl > mid) && ({1'b0, lvl} < up_edge);
  assign whl_down  = whl_armed_r && whl_idle && (lvl < mid) && (lvl_plus_dn > {1'b0, mid});
  assign whl_rearm = !whl_armed_r && (lvl < rel) &&
                     (CMP_W'(whl_cnt) > CMP_W'(whl_lock_r));

  // Next state and timer control
  always_comb begin
    btn_armed_nxt  = btn_armed_r;
    whl_armed_nxt  = whl_armed_r;
    first_seen_nxt = first_seen_r;
    btn_ctrl       = '{start: click, stop: btn_rearm};
    pair_ctrl      = '{start: click && pair_idle, stop: dbl_hit || pair_drop};
    whl_ctrl       = '{start: whl_up || whl_down, stop: whl_rearm};
    if (click) begin
      btn_armed_nxt = 1'b0;
    end else if (btn_rearm) begin
      btn_armed_nxt = 1'b1;
    end
    if (click && pair_idle) begin
      first_seen_nxt = 1'b1;
    end else if (dbl_hit) begin
      first_seen_nxt = 1'b0;
    end
    if (whl_up || whl_down) begin
      whl_armed_nxt = 1'b0;
    end else if (whl_rearm) begin
      whl_armed_nxt = 1'b1;
    end
    out_flags_nxt = {whl_down, whl_up, dbl_hit, r_click, g_click};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      btn_armed_r  <= 1'b1;
      whl_armed_r  <= 1'b1;
      first_seen_r <= 1'b0;
    end else if (step) begin
      btn_armed_r  <= btn_armed_nxt;
      whl_armed_r  <= whl_armed_nxt;
      first_seen_r <= first_seen_nxt;
    end
  end

  // Output stage: hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_flags_r <= out_flags_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-5){1'b0}}, out_flags_r};

endmodule
